// ===== src/tst_pkg.sv =====
// Package for the turnout state tracker: sizes, codes, payload and control types.
`default_nettype none
package tst_pkg;

	localparam int NUM_SWITCHES = 2048;
	localparam int IDX_W = $clog2(NUM_SWITCHES);
	localparam int SW_W = 12;
	localparam logic [SW_W-1:0] NUM_SW = SW_W'(NUM_SWITCHES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SWITCHES - 1);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_OPCODE = 1'b0;
	localparam logic REG_NOTIFY = 1'b1;
	localparam logic [7:0] OPCODE_RESET = 8'd176;

	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_CLOSED = 2'd1;
	localparam logic [1:0] ST_THROWN = 2'd2;
	localparam logic [1:0] ST_BAD = 2'd3;

	localparam logic [6:0] B2_HIGH_MASK = 7'h0F;
	localparam logic [6:0] B2_CLOSED = 7'h01 << 5;
	localparam logic [6:0] B2_OUT_ON = 7'h01 << 4;

	typedef enum logic [1:0] {
		CMD_OBSERVE = 2'd0,
		CMD_THROW = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ACK = 3'd0,
		KIND_EVENT = 3'd1,
		KIND_MSG = 3'd2,
		KIND_INVALID = 3'd3,
		KIND_QUERY = 3'd4
	} kind_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] opcode_in;
		logic [6:0] first_data;
		logic [6:0] second_data;
		logic [SW_W-1:0] switch_number;
		logic output_off_too;
	} req_t;

	typedef struct packed {
		logic [2:0] result_kind;
		logic [SW_W-1:0] event_switch;
		logic [1:0] turnout_status;
		logic [7:0] out_opcode;
		logic [6:0] out_first;
		logic [6:0] out_second;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic notify_en;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] addr;
		logic [1:0] data;
	} wr_t;

	typedef struct packed {
		kind_t kind;
		logic [SW_W-1:0] sw;
		logic [1:0] status;
		logic [7:0] opc;
		logic [6:0] first;
		logic [6:0] second;
		logic two;
	} pend_t;

endpackage
`default_nettype wire

// ===== src/tst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tst_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/tst_apb_regs.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none
module tst_apb_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [tst_pkg::APB_AW-1:0] paddr,
	input wire logic [tst_pkg::APB_DW-1:0] pwdata,
	output logic [tst_pkg::APB_DW-1:0] prdata,
	output logic pready,
	output tst_pkg::cfg_t cfg
);

	logic wr_en;
	tst_pkg::cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.opcode <= tst_pkg::OPCODE_RESET;
			cfg_q.notify_en <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				tst_pkg::REG_OPCODE: cfg_q.opcode <= pwdata[7:0];
				tst_pkg::REG_NOTIFY: cfg_q.notify_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tst_pkg::REG_OPCODE: prdata = {24'd0, cfg_q.opcode};
			tst_pkg::REG_NOTIFY: prdata = {31'd0, cfg_q.notify_en};
			default: prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/tst_eval.sv =====
// Decode of one request against its stored turnout state: store update and result.
`default_nettype none
module tst_eval (
	input wire tst_pkg::req_t req,
	input wire logic [1:0] stored,
	input wire tst_pkg::cfg_t cfg,
	output tst_pkg::wr_t wr,
	output tst_pkg::pend_t item
);

	logic [10:0] obs_idx;
	logic obs_hit;
	logic num_ok;
	logic [tst_pkg::SW_W-1:0] n;
	logic [1:0] old_state;
	logic [1:0] new_state;

	always_comb begin
		obs_idx = {req.second_data[3:0], req.first_data};
		obs_hit = (req.opcode_in == cfg.opcode) && ({1'b0, obs_idx} < tst_pkg::NUM_SW);
		num_ok = (req.switch_number != '0) && (req.switch_number <= tst_pkg::NUM_SW);
		n = req.switch_number - tst_pkg::SW_W'(1);
		old_state = (stored == tst_pkg::ST_BAD) ? tst_pkg::ST_UNKNOWN : stored;
		new_state = ((req.second_data & tst_pkg::B2_CLOSED) != '0) ?
			tst_pkg::ST_CLOSED : tst_pkg::ST_THROWN;

		wr.en = 1'b0;
		wr.addr = obs_idx[tst_pkg::IDX_W-1:0];
		wr.data = new_state;
		item = '0;
		item.kind = tst_pkg::KIND_ACK;

		unique case (req.cmd)
			tst_pkg::CMD_OBSERVE: begin
				wr.en = obs_hit;
				if (obs_hit && cfg.notify_en && (new_state != old_state)) begin
					item.kind = tst_pkg::KIND_EVENT;
					item.sw = {1'b0, obs_idx} + tst_pkg::SW_W'(1);
					item.status = new_state;
				end
			end
			tst_pkg::CMD_QUERY: begin
				item.kind = tst_pkg::KIND_QUERY;
				item.status = num_ok ? old_state : tst_pkg::ST_UNKNOWN;
			end
			tst_pkg::CMD_THROW, tst_pkg::CMD_CLOSE: begin
				if (!num_ok) begin
					item.kind = tst_pkg::KIND_INVALID;
				end else begin
					item.kind = tst_pkg::KIND_MSG;
					item.opc = cfg.opcode;
					item.first = n[6:0];
					item.second = ({3'd0, n[10:7]} & tst_pkg::B2_HIGH_MASK) |
						((req.cmd == tst_pkg::CMD_CLOSE) ? tst_pkg::B2_CLOSED : 7'd0);
					item.two = req.output_off_too;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/tst_out_stage.sv =====
// Result register that plays out one or two result items per request.
`default_nettype none
module tst_out_stage (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire tst_pkg::pend_t item,
	output logic take_ok,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output tst_pkg::rsp_t rsp
);

	logic valid_q;
	logic phase_q;
	tst_pkg::pend_t item_s2;
	logic final_now;
	logic on_bit;

	assign final_now = !item_s2.two || phase_q;
	assign take_ok = !valid_q || (rsp_ready && final_now);
	assign on_bit = (item_s2.kind == tst_pkg::KIND_MSG) && !phase_q;
	assign rsp_valid = valid_q;

	always_comb begin
		rsp.result_kind = item_s2.kind;
		rsp.event_switch = item_s2.sw;
		rsp.turnout_status = item_s2.status;
		rsp.out_opcode = item_s2.opc;
		rsp.out_first = item_s2.first;
		rsp.out_second = item_s2.second | (on_bit ? tst_pkg::B2_OUT_ON : 7'd0);
		rsp.last = final_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (take_ok) begin
			valid_q <= load;
			phase_q <= 1'b0;
		end else if (rsp_ready) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= item;
		end
	end

endmodule
`default_nettype wire

// ===== src/turnout_state_tracker.sv =====
// Top level of the turnout state tracker: input stage, state store and clearing pass.
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_ready     tst_pkg::req_t
//   rsp       out        rsp_valid / rsp_ready     tst_pkg::rsp_t
//   apb       in         psel, penable, pready     paddr, pwdata, prdata
//
// A request is registered together with its store read, and is evaluated in the next cycle;
// once the output stage can take it, the store is written back and the result lands in the
// output register, which offers it: one request per cycle unless the output stalls.
// Throw or close requests with the second message play out as two result items.
// After reset a clearing pass writes unknown to all NUM_SWITCHES entries, one a cycle,
// and req_ready stays low until it is done.
// A stalled output holds the input stage, which then holds its store read.
`default_nettype none
module turnout_state_tracker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [tst_pkg::APB_AW-1:0] paddr,
	input wire logic [tst_pkg::APB_DW-1:0] pwdata,
	output logic [tst_pkg::APB_DW-1:0] prdata,
	output logic pready,
	input wire logic req_valid,
	output logic req_ready,
	input wire tst_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output tst_pkg::rsp_t rsp
);

	tst_pkg::cfg_t cfg;
	tst_pkg::req_t req_s1;
	logic valid_s1;
	logic [tst_pkg::IDX_W-1:0] addr_s1;
	logic [tst_pkg::IDX_W-1:0] rd_addr;
	logic [10:0] obs_addr;
	logic [tst_pkg::SW_W-1:0] num_m1;
	logic accept;
	logic advance;
	logic take_ok;
	logic clearing_q;
	logic [tst_pkg::IDX_W-1:0] clr_addr_q;
	logic byp_valid_q;
	logic [tst_pkg::IDX_W-1:0] byp_addr_q;
	logic [1:0] byp_data_q;
	logic [1:0] ram_rdata;
	logic [1:0] stored;
	tst_pkg::wr_t item_wr;
	tst_pkg::pend_t item;
	logic ram_we;
	logic [tst_pkg::IDX_W-1:0] ram_waddr;
	logic [1:0] ram_wdata;

	tst_apb_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign advance = valid_s1 && take_ok;
	assign req_ready = !clearing_q && (!valid_s1 || take_ok);
	assign accept = req_valid && req_ready;

	always_comb begin
		num_m1 = req.switch_number - tst_pkg::SW_W'(1);
		obs_addr = {req.second_data[3:0], req.first_data};
		if (req.cmd == tst_pkg::CMD_QUERY) begin
			rd_addr = num_m1[tst_pkg::IDX_W-1:0];
		end else begin
			rd_addr = obs_addr[tst_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + tst_pkg::IDX_W'(1);
			if (clr_addr_q == tst_pkg::LAST_IDX) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else if (advance && item_wr.en) begin
			byp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_wr.en) begin
			byp_addr_q <= item_wr.addr;
			byp_data_q <= item_wr.data;
		end
	end

	assign stored = (byp_valid_q && (byp_addr_q == addr_s1)) ? byp_data_q : ram_rdata;

	tst_eval u_eval (
		.req(req_s1),
		.stored(stored),
		.cfg(cfg),
		.wr(item_wr),
		.item(item)
	);

	always_comb begin
		if (clearing_q) begin
			ram_we = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = tst_pkg::ST_UNKNOWN;
		end else begin
			ram_we = advance && item_wr.en;
			ram_waddr = item_wr.addr;
			ram_wdata = item_wr.data;
		end
	end

	tst_ram #(
		.WIDTH(2),
		.DEPTH(tst_pkg::NUM_SWITCHES)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(accept),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	tst_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance),
		.item(item),
		.take_ok(take_ok),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule
`default_nettype wire

// ===== src/tst_checker.sv =====
// Port-level checks of the turnout state tracker and their binding to the top level.
`default_nettype none
module tst_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire tst_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Result changed or dropped while stalled.");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.result_kind <= tst_pkg::KIND_QUERY)
		else $error("Result kind out of range.");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind != tst_pkg::KIND_MSG |-> rsp.last)
		else $error("Only request messages may come in pairs.");

	a_second_msg: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last |=>
		rsp_valid && rsp.last && rsp.result_kind == tst_pkg::KIND_MSG &&
		(rsp.out_second & tst_pkg::B2_OUT_ON) == 7'd0)
		else $error("First message not followed by its output-off message.");

	a_event_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == tst_pkg::KIND_EVENT |->
		rsp.event_switch != '0 &&
		(rsp.turnout_status == tst_pkg::ST_CLOSED || rsp.turnout_status == tst_pkg::ST_THROWN))
		else $error("Change event with bad switch or state.");

endmodule

bind turnout_state_tracker tst_checker u_tst_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp(rsp)
);
`default_nettype wire
